@@ src/weather_sensor_frame_decoder_defines.svh @@
// Assertion macros for the weather sensor telegram decoder.
// Clocked on clk_i and disabled while rst_ni is low; no other dependencies.
`ifndef WEATHER_SENSOR_FRAME_DECODER_DEFINES_SVH
`define WEATHER_SENSOR_FRAME_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define WSFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define WSFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WSFD_ASSERT_NOW(label, ante, cons)
`define WSFD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ src/wsfd_pkg.sv @@
// Shared types, constants and the CRC-8 byte update for the weather sensor
// telegram decoder. No dependencies.
package wsfd_pkg;

  // Telegram constants.
  localparam logic [3:0]  HeaderNibble = 4'hA;
  localparam logic [7:0]  CrcPoly      = 8'h31;
  localparam logic [11:0] TempOffset   = 12'd400;
  localparam logic [10:0] TempMaxBcd   = 11'd1000;
  localparam logic [10:0] HumMaxBcd    = 11'd100;
  localparam int unsigned ErrFlagBit   = 4;

  // Quartet type codes carried in the upper nibble of the first quartet byte.
  typedef enum logic [3:0] {
    KIND_TEMP = 4'd0,
    KIND_HUM  = 4'd1,
    KIND_RAIN = 4'd2,
    KIND_WIND = 4'd3,
    KIND_GUST = 4'd4
  } qkind_e;

  // MSB-first CRC-8 update of one byte.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = data[i] ^ c[7];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage

@@ src/weather_sensor_frame_decoder.sv @@
// Top level of the weather sensor telegram decoder: byte-wise decode and
// the result register. Depends on wsfd_pkg and the assertion macro header.
`include "weather_sensor_frame_decoder_defines.svh"

// Usage:
// The input channel (in_valid_i / in_stall_o) carries one telegram byte per
// item; frame_start_i marks byte 0 and restarts any telegram in progress.
// Bytes arriving with frame_start_i low outside a telegram are dropped.
// The output channel (out_valid_o / out_stall_i) carries one record per
// telegram, produced by the item that holds the CRC byte.
// Each byte is decoded in the cycle it is accepted: the CRC update, the
// quartet decode and the record assembly sit between the frame state and
// the result register, so one item is taken every cycle while in_stall_o
// is low; a record is shown in the cycle after its CRC byte is accepted.
// The result register lets a new item in while a record waits, as long as
// it is being taken in that cycle; while the receiver stalls a pending
// record, in_stall_o is high and the record holds.
// Reset clears the frame state and the result valid flag; the block is
// ready as soon as reset is released.
module weather_sensor_frame_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               valid_res_o,
  output logic [5:0]         sensor_id_o,
  output logic [2:0]         status_flags_o,
  output logic [4:0]         present_mask_o,
  output logic signed [11:0] temperature_tenths_o,
  output logic [10:0]        humidity_percent_o,
  output logic [11:0]        rain_count_o,
  output logic [3:0]         wind_direction_o,
  output logic [7:0]         wind_speed_tenths_o,
  output logic [7:0]         gust_tenths_o
);

  // Frame state.
  logic [4:0]  byte_pos_q, byte_pos_d;
  logic        frame_active_q, frame_active_d;
  logic [2:0]  quartet_cnt_q, quartet_cnt_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  header_q, header_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  pending_q, pending_d;
  logic        range_err_q, range_err_d;
  logic [4:0]  found_q, found_d;
  logic [10:0] temp_q, temp_d;
  logic [10:0] hum_q, hum_d;
  logic [11:0] rain_q, rain_d;
  logic [11:0] wind_q, wind_d;
  logic [7:0]  gust_q, gust_d;

  // Result register.
  logic        out_valid_q;
  logic        res_valid_q, res_valid_d;
  logic [5:0]  res_id_q, res_id_d;
  logic [2:0]  res_flags_q, res_flags_d;
  logic [4:0]  res_mask_q, res_mask_d;
  logic [11:0] res_temp_q, res_temp_d;
  logic [10:0] res_hum_q, res_hum_d;
  logic [11:0] res_rain_q, res_rain_d;
  logic [3:0]  res_dir_q, res_dir_d;
  logic [7:0]  res_speed_q, res_speed_d;
  logic [7:0]  res_gust_q, res_gust_d;

  logic        in_accept;
  logic        out_accept;
  logic        emit;
  logic        active;
  logic [4:0]  last_pos;
  logic [10:0] bcd;
  logic        err_flag;
  logic [7:0]  crc_cur;
  logic [3:0]  kind;

  // Handshake: take a byte unless a record is waiting and stalled.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;

  // Per-byte decode. A start byte begins from a cleared frame.
  always_comb begin
    byte_pos_d     = frame_start_i ? '0 : byte_pos_q;
    frame_active_d = frame_start_i | frame_active_q;
    quartet_cnt_d  = frame_start_i ? '0 : quartet_cnt_q;
    crc_d          = frame_start_i ? '0 : crc_q;
    header_d       = frame_start_i ? '0 : header_q;
    flags_d        = frame_start_i ? '0 : flags_q;
    pending_d      = frame_start_i ? '0 : pending_q;
    range_err_d    = frame_start_i ? 1'b0 : range_err_q;
    found_d        = frame_start_i ? '0 : found_q;
    temp_d         = frame_start_i ? '0 : temp_q;
    hum_d          = frame_start_i ? '0 : hum_q;
    rain_d         = frame_start_i ? '0 : rain_q;
    wind_d         = frame_start_i ? '0 : wind_q;
    gust_d         = frame_start_i ? '0 : gust_q;

    active   = frame_active_d;
    crc_cur  = crc_d;
    last_pos = {1'b0, quartet_cnt_d, 1'b0} + 5'd2;
    err_flag = flags_d[wsfd_pkg::ErrFlagBit];
    kind     = pending_d[7:4];
    bcd      = 11'(pending_d[3:0]) * 11'd100 + 11'(data_byte_i[7:4]) * 11'd10
             + 11'(data_byte_i[3:0]);
    emit     = 1'b0;

    if (active) begin
      if (byte_pos_d == 5'd0) begin
        header_d   = data_byte_i;
        crc_d      = wsfd_pkg::crc8_update(crc_cur, data_byte_i);
        byte_pos_d = 5'd1;
      end else if (byte_pos_d == 5'd1) begin
        flags_d       = data_byte_i;
        quartet_cnt_d = data_byte_i[2:0];
        crc_d         = wsfd_pkg::crc8_update(crc_cur, data_byte_i);
        byte_pos_d    = 5'd2;
      end else if (byte_pos_d < last_pos) begin
        crc_d = wsfd_pkg::crc8_update(crc_cur, data_byte_i);
        if (!byte_pos_d[0]) begin
          pending_d = data_byte_i;
        end else begin
          // Second quartet byte: decode by type.
          case (wsfd_pkg::qkind_e'(kind))
            wsfd_pkg::KIND_TEMP: begin
              found_d[0] = 1'b1;
              temp_d     = bcd;
              if (bcd > wsfd_pkg::TempMaxBcd) begin
                range_err_d = 1'b1;
              end
            end
            wsfd_pkg::KIND_HUM: begin
              found_d[1] = 1'b1;
              hum_d      = bcd;
              if (bcd > wsfd_pkg::HumMaxBcd) begin
                range_err_d = 1'b1;
              end
            end
            wsfd_pkg::KIND_RAIN: begin
              if (!err_flag) begin
                found_d[2] = 1'b1;
                rain_d     = {pending_d[3:0], data_byte_i};
              end
            end
            wsfd_pkg::KIND_WIND: begin
              if (!err_flag) begin
                found_d[3] = 1'b1;
                wind_d     = {pending_d[3:0], data_byte_i};
              end
            end
            wsfd_pkg::KIND_GUST: begin
              if (!err_flag) begin
                found_d[4] = 1'b1;
                gust_d     = data_byte_i;
              end
            end
            default: begin
            end
          endcase
        end
        byte_pos_d = byte_pos_d + 5'd1;
      end else begin
        // CRC byte: close the telegram.
        emit           = 1'b1;
        frame_active_d = 1'b0;
        byte_pos_d     = '0;
      end
    end
  end

  // Record assembly; a bad header or CRC gives an all-zero record.
  always_comb begin
    res_valid_d = 1'b0;
    res_id_d    = '0;
    res_flags_d = '0;
    res_mask_d  = '0;
    res_temp_d  = '0;
    res_hum_d   = '0;
    res_rain_d  = '0;
    res_dir_d   = '0;
    res_speed_d = '0;
    res_gust_d  = '0;
    if (header_d[7:4] == wsfd_pkg::HeaderNibble && crc_cur == data_byte_i) begin
      res_valid_d = !range_err_d;
      res_id_d    = {header_d[3:0], flags_d[7:6]};
      res_flags_d = flags_d[5:3];
      res_mask_d  = found_d;
      if (found_d[0]) begin
        res_temp_d = 12'(temp_d) - wsfd_pkg::TempOffset;
      end
      res_hum_d   = hum_d;
      res_rain_d  = rain_d;
      res_dir_d   = wind_d[11:8];
      res_speed_d = wind_d[7:0];
      res_gust_d  = gust_d;
    end
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q     <= '0;
      frame_active_q <= 1'b0;
      quartet_cnt_q  <= '0;
      crc_q          <= '0;
      header_q       <= '0;
      flags_q        <= '0;
      pending_q      <= '0;
      range_err_q    <= 1'b0;
      found_q        <= '0;
      temp_q         <= '0;
      hum_q          <= '0;
      rain_q         <= '0;
      wind_q         <= '0;
      gust_q         <= '0;
    end else if (in_accept) begin
      byte_pos_q     <= byte_pos_d;
      frame_active_q <= frame_active_d;
      quartet_cnt_q  <= quartet_cnt_d;
      crc_q          <= crc_d;
      header_q       <= header_d;
      flags_q        <= flags_d;
      pending_q      <= pending_d;
      range_err_q    <= range_err_d;
      found_q        <= found_d;
      temp_q         <= temp_d;
      hum_q          <= hum_d;
      rain_q         <= rain_d;
      wind_q         <= wind_d;
      gust_q         <= gust_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_accept) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded only when a record is produced.
  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      res_valid_q <= res_valid_d;
      res_id_q    <= res_id_d;
      res_flags_q <= res_flags_d;
      res_mask_q  <= res_mask_d;
      res_temp_q  <= res_temp_d;
      res_hum_q   <= res_hum_d;
      res_rain_q  <= res_rain_d;
      res_dir_q   <= res_dir_d;
      res_speed_q <= res_speed_d;
      res_gust_q  <= res_gust_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign valid_res_o          = res_valid_q;
  assign sensor_id_o          = res_id_q;
  assign status_flags_o       = res_flags_q;
  assign present_mask_o       = res_mask_q;
  assign temperature_tenths_o = $signed(res_temp_q);
  assign humidity_percent_o   = res_hum_q;
  assign rain_count_o         = res_rain_q;
  assign wind_direction_o     = res_dir_q;
  assign wind_speed_tenths_o  = res_speed_q;
  assign gust_tenths_o        = res_gust_q;

  // Checks on the decoder's own control.
  `WSFD_ASSERT_NOW(a_stall_blocks_input, out_valid_q && out_stall_i, !in_accept)
  `WSFD_ASSERT_NOW(a_idle_pos_zero, !frame_active_q, byte_pos_q == 5'd0)
  `WSFD_ASSERT_NEXT(a_emit_sets_valid, in_accept && emit, out_valid_q && !frame_active_q)

endmodule
